// ===== rtl/gprcf_pkg.sv =====
// Shared types, constants and helpers for the gamepad report change filter.
// No dependencies.
package gprcf_pkg;

    localparam int unsigned PAYLOAD_BYTES_DEF = 14;
    localparam int unsigned DATA_BYTES        = 12;   // bytes that carry pad state
    localparam int unsigned DATA_IDX_W        = 4;

    localparam logic [15:0] STICK_THR_RST  = 16'd256;
    localparam logic [7:0]  TRIG_THR_RST   = 8'd8;
    localparam logic [15:0] HB_PERIOD_RST  = 16'd16;
    localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STICK_THR = 2'd0,
        CFG_TRIG_THR  = 2'd1,
        CFG_HB_PERIOD = 2'd2
    } t_cfg_idx;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Reverse bit order within a byte.
    function automatic logic [7:0] flip_byte(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

endpackage

// ===== rtl/gprcf_in_if.sv =====
// Input channel: gamepad reports and millisecond ticks.
// Depends on nothing.
interface gprcf_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [15:0]        buttons;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;

    modport source (
        output valid, kind, buttons, left_x, left_y, right_x, right_y,
               left_trigger, right_trigger,
        input  ready
    );
    modport sink (
        input  valid, kind, buttons, left_x, left_y, right_x, right_y,
               left_trigger, right_trigger,
        output ready
    );
endinterface

// ===== rtl/gprcf_out_if.sv =====
// Output channel: bit-reversed payload bytes.
// Depends on nothing.
interface gprcf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_byte;

    modport source (output valid, payload_byte, last_byte, input ready);
    modport sink   (input valid, payload_byte, last_byte, output ready);
endinterface

// ===== rtl/gamepad_report_change_filter_core.sv =====
// Gamepad report change filter, top level.
// Depends on gprcf_pkg, gprcf_in_if, gprcf_out_if.
//
// Usage:
//   i_item carries one item per handshake: a gamepad report (kind 0) or a
//   one millisecond tick (kind 1; other fields ignored). o_item carries
//   payload bytes, bit reversed, PAYLOAD_BYTES per send, last_byte set on
//   the final one. The user must write the config port (stick threshold 0,
//   trigger threshold 1, heartbeat period 2) only while idle, which the block does not enforce.
//
//   Accepted items land in an input register, where the send decision is
//   made combinationally against the held pad and elapsed count; a sent
//   report replaces the held pad. The first byte of a send is registered
//   once the byte emitter is free, then one byte per cycle while o_item is ready.
//
//   Throughput: items that cause no send go through one per cycle while no
//   send waits ahead of them. An item that sends waits in the input register
//   until the byte emitter is free, so a send occupies the emitter until its
//   last byte is taken; its successor can be decided in that cycle.
//
//   Reset (synchronous, active low) clears held pad and count, loads the
//   register defaults and drops both valids. A stall on o_item holds the
//   current byte and backs up into i_item.ready once a send is pending.
module gamepad_report_change_filter_core
    import gprcf_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    gprcf_in_if.sink              i_item,
    gprcf_out_if.source           o_item
);

    localparam int unsigned IDX_W    = $clog2(PAYLOAD_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

    // config
    logic [15:0] r_stick_thr;
    logic [7:0]  r_trig_thr;
    logic [15:0] r_hb_period;

    // input register
    logic               r_in_valid;
    logic               r_kind;
    logic [15:0]        r_buttons;
    logic signed [15:0] r_lx, r_ly, r_rx, r_ry;
    logic [7:0]         r_lt, r_rt;

    // held pad and elapsed count
    logic [15:0] r_held_buttons, n_held_buttons;
    logic [15:0] r_held_lx, r_held_ly, r_held_rx, r_held_ry;
    logic [15:0] n_held_lx, n_held_ly, n_held_rx, n_held_ry;
    logic [7:0]  r_held_lt, r_held_rt, n_held_lt, n_held_rt;
    logic [15:0] r_elapsed, n_elapsed;

    // byte emitter
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_last;

    logic        send, emit_free, send_go, in_consume;
    logic [15:0] elapsed_inc;
    logic        changed;

    function automatic logic [16:0] stick_dist(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] d;
        d = {a[15], a} - {b[15], b};
        return d[16] ? (~d + 17'd1) : d;
    endfunction

    function automatic logic [8:0] trig_dist(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] d;
        d = {1'b0, a} - {1'b0, b};
        return d[8] ? (~d + 9'd1) : d;
    endfunction

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stick_thr <= STICK_THR_RST;
            r_trig_thr  <= TRIG_THR_RST;
            r_hb_period <= HB_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STICK_THR: r_stick_thr <= i_cfg_data;
                CFG_TRIG_THR:  r_trig_thr  <= i_cfg_data[7:0];
                CFG_HB_PERIOD: r_hb_period <= i_cfg_data;
                default: ;  // unused index
            endcase
        end
    end

    // ---------------- input register ----------------
    assign i_item.ready = !r_in_valid || in_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_kind    <= i_item.kind;
            r_buttons <= i_item.buttons;
            r_lx      <= i_item.left_x;
            r_ly      <= i_item.left_y;
            r_rx      <= i_item.right_x;
            r_ry      <= i_item.right_y;
            r_lt      <= i_item.left_trigger;
            r_rt      <= i_item.right_trigger;
        end
    end

    // ---------------- send decision ----------------
    assign elapsed_inc = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 16'd1;

    assign changed = (r_buttons != r_held_buttons)
                  || (stick_dist(r_lx, r_held_lx) > {1'b0, r_stick_thr})
                  || (stick_dist(r_ly, r_held_ly) > {1'b0, r_stick_thr})
                  || (stick_dist(r_rx, r_held_rx) > {1'b0, r_stick_thr})
                  || (stick_dist(r_ry, r_held_ry) > {1'b0, r_stick_thr})
                  || (trig_dist(r_lt, r_held_lt) > {1'b0, r_trig_thr})
                  || (trig_dist(r_rt, r_held_rt) > {1'b0, r_trig_thr});

    always_comb begin
        if (r_kind == KIND_TICK) begin
            send = (elapsed_inc >= r_hb_period);
        end else begin
            send = (r_elapsed >= r_hb_period) || changed;
        end
    end

    assign emit_free  = !r_out_valid || (o_item.ready && r_out_last);
    assign send_go    = r_in_valid && send && emit_free;
    assign in_consume = r_in_valid && (!send || emit_free);

    always_comb begin
        n_held_buttons = r_held_buttons;
        n_held_lx      = r_held_lx;
        n_held_ly      = r_held_ly;
        n_held_rx      = r_held_rx;
        n_held_ry      = r_held_ry;
        n_held_lt      = r_held_lt;
        n_held_rt      = r_held_rt;
        n_elapsed      = r_elapsed;
        if (in_consume) begin
            if (r_kind == KIND_TICK) begin
                n_elapsed = elapsed_inc;
            end else if (send) begin
                n_held_buttons = r_buttons;
                n_held_lx      = r_lx;
                n_held_ly      = r_ly;
                n_held_rx      = r_rx;
                n_held_ry      = r_ry;
                n_held_lt      = r_lt;
                n_held_rt      = r_rt;
            end
            if (send) begin
                n_elapsed = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_buttons <= '0;
            r_held_lx      <= '0;
            r_held_ly      <= '0;
            r_held_rx      <= '0;
            r_held_ry      <= '0;
            r_held_lt      <= '0;
            r_held_rt      <= '0;
            r_elapsed      <= '0;
        end else begin
            r_held_buttons <= n_held_buttons;
            r_held_lx      <= n_held_lx;
            r_held_ly      <= n_held_ly;
            r_held_rx      <= n_held_rx;
            r_held_ry      <= n_held_ry;
            r_held_lt      <= n_held_lt;
            r_held_rt      <= n_held_rt;
            r_elapsed      <= n_elapsed;
        end
    end

    // ---------------- byte emitter ----------------
    // Bytes are read straight from the held pad: it only changes on a send,
    // and a send waits until the previous payload is out.
    logic [7:0] data_bytes [DATA_BYTES];

    always_comb begin
        data_bytes[0]  = n_held_buttons[7:0];
        data_bytes[1]  = n_held_buttons[15:8];
        data_bytes[2]  = n_held_lx[7:0];
        data_bytes[3]  = n_held_lx[15:8];
        data_bytes[4]  = n_held_ly[7:0];
        data_bytes[5]  = n_held_ly[15:8];
        data_bytes[6]  = n_held_rx[7:0];
        data_bytes[7]  = n_held_rx[15:8];
        data_bytes[8]  = n_held_ry[7:0];
        data_bytes[9]  = n_held_ry[15:8];
        data_bytes[10] = n_held_lt;
        data_bytes[11] = n_held_rt;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_idx       = r_idx;
        if (send_go) begin
            n_out_valid = 1'b1;
            n_idx       = '0;
        end else if (r_out_valid && o_item.ready) begin
            if (r_out_last) begin
                n_out_valid = 1'b0;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
        if (n_idx < IDX_W'(DATA_BYTES)) begin
            n_out_byte = flip_byte(data_bytes[n_idx[DATA_IDX_W-1:0]]);
        end else begin
            n_out_byte = 8'd0;  // padding
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= (n_idx == LAST_IDX);
    end

    assign o_item.valid        = r_out_valid;
    assign o_item.payload_byte = r_out_byte;
    assign o_item.last_byte    = r_out_last;

`ifndef SYNTHESIS
    a_no_early_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !(o_item.ready && r_out_last)) |=> r_out_valid)
        else $error("payload dropped before last byte was taken");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_item.ready && !r_out_last) |=>
            (r_idx == $past(r_idx) + IDX_W'(1)))
        else $error("byte index did not advance by one");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_item.ready) |=> ($stable(r_idx) && $stable(r_out_byte)))
        else $error("stalled byte changed");

    a_send_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        send_go |=> (r_elapsed == 16'd0))
        else $error("elapsed count not cleared on send");
`endif

endmodule

// ===== tb/gamepad_report_change_filter_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gamepad_report_change_filter_core: directed and random
// reports/ticks, checked byte by byte against an in-bench model of the filter.
// Depends on gprcf_pkg, gprcf_in_if, gprcf_out_if and the core itself.
module gamepad_report_change_filter_core_test;
    import gprcf_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 6;     // covers the decision and first byte
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int NBYTES          = PAYLOAD_BYTES_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    typedef struct {
        logic               kind;
        logic [15:0]        buttons;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic [7:0]         lt;
        logic [7:0]         rt;
    } t_pad_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_pay_byte;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gprcf_in_if  in_ch ();
    gprcf_out_if out_ch ();

    gamepad_report_change_filter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (in_ch),
        .o_item     (out_ch)
    );

    // Filter model state and its copy of the registers.
    logic [15:0] stick_limit;
    logic [7:0]  trig_limit;
    logic [15:0] period;
    logic [15:0] held_buttons;
    logic [15:0] held_stick [4];
    logic [7:0]  held_trig [2];
    logic [15:0] elapsed_ms;

    t_pay_byte pending_bytes [$];
    t_pay_byte want;
    int        err_count   = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        rx_hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Cycle limit.
    initial begin
        for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge i_clk);
        $display("gamepad_report_change_filter_core_test: done, errors");
        $finish;
    end

    // Sink side: random ready, or a long hold-off when one is requested.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Byte checker: every taken byte against the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected payload byte %02h (last %0b)",
                       out_ch.payload_byte, out_ch.last_byte);
                err_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (out_ch.payload_byte !== want.data) begin
                    $error("payload_byte: expected %02h, got %02h",
                           want.data, out_ch.payload_byte);
                    err_count++;
                end
                if (out_ch.last_byte !== want.last) begin
                    $error("last_byte: expected %0b, got %0b",
                           want.last, out_ch.last_byte);
                    err_count++;
                end
            end
        end
    end

    // Bytes of the held pad, bit reversed; a send also clears the ms count.
    function automatic void queue_payload();
        logic [7:0] raw [NBYTES];
        t_pay_byte  e;
        for (int i = 0; i < NBYTES; i++) raw[i] = 8'h00;
        raw[0] = held_buttons[7:0];
        raw[1] = held_buttons[15:8];
        for (int k = 0; k < 4; k++) begin
            raw[2 + 2 * k] = held_stick[k][7:0];
            raw[3 + 2 * k] = held_stick[k][15:8];
        end
        raw[10] = held_trig[0];
        raw[11] = held_trig[1];
        for (int i = 0; i < NBYTES; i++) begin
            e.data = {<<{raw[i]}};
            e.last = (i == NBYTES - 1);
            pending_bytes.push_back(e);
        end
        elapsed_ms = 16'd0;
    endfunction

    // Send decision for one accepted item.
    function automatic void predict_filter(input t_pad_item it);
        logic [15:0] axis [4];
        logic [7:0]  trig [2];
        bit          send;
        int          d;
        if (it.kind == KIND_TICK) begin
            if (elapsed_ms != ELAPSED_MAX) elapsed_ms++;
            if (elapsed_ms >= period) queue_payload();
        end else begin
            axis[0] = it.lx;
            axis[1] = it.ly;
            axis[2] = it.rx;
            axis[3] = it.ry;
            trig[0] = it.lt;
            trig[1] = it.rt;
            send = (elapsed_ms >= period) || (it.buttons != held_buttons);
            for (int k = 0; k < 4; k++) begin
                d = int'($signed(axis[k])) - int'($signed(held_stick[k]));
                if (d < 0) d = -d;
                if (d > int'(stick_limit)) send = 1'b1;
            end
            for (int k = 0; k < 2; k++) begin
                d = int'(trig[k]) - int'(held_trig[k]);
                if (d < 0) d = -d;
                if (d > int'(trig_limit)) send = 1'b1;
            end
            if (send) begin
                held_buttons = it.buttons;
                for (int k = 0; k < 4; k++) held_stick[k] = axis[k];
                held_trig[0] = trig[0];
                held_trig[1] = trig[1];
                queue_payload();
            end
        end
    endfunction

    function automatic t_pad_item mk_report(input logic [15:0] b,
                                            input logic signed [15:0] lx,
                                            input logic signed [15:0] ly,
                                            input logic signed [15:0] rx,
                                            input logic signed [15:0] ry,
                                            input logic [7:0] lt,
                                            input logic [7:0] rt);
        t_pad_item it;
        it.kind    = KIND_REPORT;
        it.buttons = b;
        it.lx      = lx;
        it.ly      = ly;
        it.rx      = rx;
        it.ry      = ry;
        it.lt      = lt;
        it.rt      = rt;
        return it;
    endfunction

    function automatic t_pad_item mk_random_report();
        return mk_report(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Tick with junk in the ignored fields.
    function automatic t_pad_item mk_tick();
        t_pad_item it;
        it = mk_random_report();
        it.kind = KIND_TICK;
        return it;
    endfunction

    function automatic t_pad_item held_report();
        return mk_report(held_buttons, held_stick[0], held_stick[1], held_stick[2],
                         held_stick[3], held_trig[0], held_trig[1]);
    endfunction

    // Mostly small edits of the held pad, landing near the thresholds.
    function automatic t_pad_item make_random_item();
        t_pad_item          it;
        int                 sel;
        int                 delta;
        int                 k;
        logic signed [15:0] moved;
        it  = held_report();
        sel = $urandom_range(99);
        if (sel < 25) begin
            it = mk_tick();
        end else if (sel < 42) begin
            it = mk_random_report();
        end else if (sel < 55) begin
            // unchanged pad: only the heartbeat can send it
        end else if (sel < 68) begin
            it.buttons = it.buttons ^ (16'd1 << $urandom_range(15));
        end else if (sel < 86) begin
            k     = $urandom_range(3);
            delta = int'(stick_limit) + int'($urandom_range(2)) - 1;
            if ($urandom_range(1)) delta = -delta;
            moved = 16'(int'($signed(held_stick[k])) + delta);
            case (k)
                0: it.lx = moved;
                1: it.ly = moved;
                2: it.rx = moved;
                default: it.ry = moved;
            endcase
        end else begin
            delta = int'(trig_limit) + int'($urandom_range(2)) - 1;
            if ($urandom_range(1)) delta = -delta;
            if ($urandom_range(1)) it.lt = 8'(int'(held_trig[0]) + delta);
            else                   it.rt = 8'(int'(held_trig[1]) + delta);
        end
        return it;
    endfunction

    // One item onto the input channel; valid stays up after acceptance.
    task automatic send_item(input t_pad_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.kind          <= it.kind;
        in_ch.buttons       <= it.buttons;
        in_ch.left_x        <= it.lx;
        in_ch.left_y        <= it.ly;
        in_ch.right_x       <= it.rx;
        in_ch.right_y       <= it.ry;
        in_ch.left_trigger  <= it.lt;
        in_ch.right_trigger <= it.rt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_filter(it);
    endtask

    // Drop valid, wait out all expected bytes plus pipeline latency.
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_STICK_THR: stick_limit = value;
            CFG_TRIG_THR:  trig_limit  = value[7:0];
            CFG_HB_PERIOD: period      = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Threshold edges at the reset register values: exactly-at-limit holds,
    // one past sends; sticks and triggers at their extremes.
    task automatic test_thresholds();
        tx_idle_pct = 21;
        rx_idle_pct = 74;
        send_item(mk_report(16'h0000, 16'(0), 16'(0), 16'(0), 16'(0), 8'd0, 8'd0));
        send_item(mk_report(16'hFFFF, 16'(32767), 16'(-32768), 16'(-32768), 16'(32767),
                            8'd255, 8'd0));
        send_item(mk_report(16'hFFFF, 16'(32511), 16'(-32768), 16'(-32768), 16'(32767),
                            8'd255, 8'd0));
        send_item(mk_report(16'hFFFF, 16'(32511), 16'(-32511), 16'(-32768), 16'(32767),
                            8'd255, 8'd0));
        send_item(mk_report(16'hFFFF, 16'(32511), 16'(-32511), 16'(-32768), 16'(32767),
                            8'd247, 8'd0));
        send_item(mk_report(16'hFFFF, 16'(32511), 16'(-32511), 16'(-32768), 16'(32767),
                            8'd247, 8'd9));
        send_item(mk_report(16'h7FFF, 16'(32511), 16'(-32511), 16'(-32768), 16'(32767),
                            8'd247, 8'd9));
        send_item(mk_report(16'h7FFF, 16'(-32768), 16'(-32511), 16'(32767), 16'(-32768),
                            8'd247, 8'd9));
        wait_idle();
    endtask

    // Ticks up to the period resend the held pad; an unchanged report
    // below the period does not.
    task automatic test_heartbeat();
        cfg_write(CFG_HB_PERIOD, 16'd3);
        send_item(mk_tick());
        send_item(mk_tick());
        send_item(held_report());
        send_item(mk_tick());
        send_item(mk_tick());
        wait_idle();
    endtask

    // Count built up under a long period, then the period drops below it.
    task automatic test_period_lowered();
        cfg_write(CFG_HB_PERIOD, 16'd16);
        repeat (4) send_item(mk_tick());
        wait_idle();
        cfg_write(CFG_HB_PERIOD, 16'd2);
        send_item(held_report());
        wait_idle();
    endtask

    // Period zero: every report and every tick sends.
    task automatic test_period_zero();
        cfg_write(CFG_HB_PERIOD, 16'd0);
        send_item(held_report());
        send_item(mk_tick());
        wait_idle();
        cfg_write(CFG_HB_PERIOD, 16'd16);
    endtask

    // A write to the unused index must not touch the stick threshold.
    task automatic test_unused_cfg_index();
        t_pad_item it;
        cfg_write(CFG_IDX_UNUSED, 16'h0000);
        it    = held_report();
        it.lx = 16'(int'($signed(held_stick[0])) + 100);
        send_item(it);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n, input int tx_pct, input int rx_pct,
                                       input logic [15:0] stick, input logic [15:0] trig,
                                       input logic [15:0] hb);
        cfg_write(CFG_STICK_THR, stick);
        cfg_write(CFG_TRIG_THR, trig);
        cfg_write(CFG_HB_PERIOD, hb);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n) send_item(make_random_item());
        wait_idle();
    endtask

    // Sink held off while sends keep coming: the core must back up its input.
    task automatic test_backpressure();
        t_pad_item it;
        cfg_write(CFG_STICK_THR, 16'd256);
        cfg_write(CFG_TRIG_THR, 16'd8);
        cfg_write(CFG_HB_PERIOD, 16'd16);
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_left = HOLD_OFF_CYCLES;
        for (int i = 0; i < 10; i++) begin
            it         = held_report();
            it.buttons = it.buttons ^ (16'd1 << i);
            send_item(it);
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_STICK_THR;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.kind          = KIND_REPORT;
        in_ch.buttons       = '0;
        in_ch.left_x        = '0;
        in_ch.left_y        = '0;
        in_ch.right_x       = '0;
        in_ch.right_y       = '0;
        in_ch.left_trigger  = '0;
        in_ch.right_trigger = '0;

        stick_limit  = STICK_THR_RST;
        trig_limit   = TRIG_THR_RST;
        period       = HB_PERIOD_RST;
        held_buttons = '0;
        for (int k = 0; k < 4; k++) held_stick[k] = '0;
        held_trig[0] = '0;
        held_trig[1] = '0;
        elapsed_ms   = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_thresholds();
        test_heartbeat();
        test_period_lowered();
        test_period_zero();
        test_unused_cfg_index();
        // Saturation of the ms count is unreachable: any period fits 16 bits,
        // so the count is always cleared by a send before it could pin.
        test_random_traffic(110, 21, 74, 16'd0, 16'd255, 16'd1);
        test_random_traffic(110, 74, 21, 16'hFFFF, 16'd0, 16'hFFFF);
        test_random_traffic(110, 0, 0, 16'($urandom_range(1, 4000)),
                            16'($urandom_range(1, 254)), 16'($urandom_range(2, 12)));
        test_backpressure();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("gamepad_report_change_filter_core_test: done, clean");
        end else begin
            $display("gamepad_report_change_filter_core_test: done, errors");
        end
        $finish;
    end

endmodule
